[sv/multi_delimiter_record_splitter_top_defines.svh]
// Assertion macros shared by the record splitter modules.
`ifndef MULTI_DELIMITER_RECORD_SPLITTER_TOP_DEFINES_SVH
`define MULTI_DELIMITER_RECORD_SPLITTER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MDRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mdrs_pkg.sv]
// Package: constants, types and byte compare for the record splitter.
package mdrs_pkg;

	localparam int NUM_SEPARATORS = 4;
	localparam int MAX_SEP_LEN    = 8;
	localparam int NUM_SEP_REGS   = 4;
	localparam int SEP_W          = 64;
	localparam int LEN_W          = 4;
	localparam int LENS_W         = 16;
	localparam int IDX_W          = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int FILL_W         = $clog2(MAX_SEP_LEN + 1);
	localparam int POS_W          = (MAX_SEP_LEN > 1) ? $clog2(MAX_SEP_LEN) : 1;
	localparam int SUM_W          = LEN_W + 1;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFS   = 8'h20;

	localparam logic [SEP_W-1:0]  RST_SEP_0     = 64'd10;
	localparam logic [SEP_W-1:0]  RST_SEP_1     = 64'd2573;
	localparam logic [SEP_W-1:0]  RST_SEP_2     = 64'd0;
	localparam logic [SEP_W-1:0]  RST_SEP_3     = 64'd0;
	localparam logic [LENS_W-1:0] RST_LENGTHS   = 16'd33;
	localparam logic              RST_CASE      = 1'b1;
	localparam logic              RST_ESC_EN    = 1'b0;
	localparam logic [7:0]        RST_ESC_BYTE  = 8'd92;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEP_0    = 3'd0,
		REG_SEP_1    = 3'd1,
		REG_SEP_2    = 3'd2,
		REG_SEP_3    = 3'd3,
		REG_LENGTHS  = 3'd4,
		REG_CASE     = 3'd5,
		REG_ESC_EN   = 3'd6,
		REG_ESC_BYTE = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_SEP_REGS-1:0][SEP_W-1:0] sep;
		logic [LENS_W-1:0]                  lengths;
		logic                               case_sensitive;
		logic                               escape_enable;
		logic [7:0]                         escape_byte;
	} cfg_t;

	typedef struct packed {
		logic                              load;
		logic [MAX_SEP_LEN-1:0][7:0]       hist;
		logic [POS_W-1:0]                  pos;
		logic [FILL_W-1:0]                 cnt;
		logic                              term;
		logic                              matched;
		logic [IDX_W-1:0]                  idx;
	} drain_ld_t;

	function automatic logic bytes_equal(logic [7:0] d, logic [7:0] s, logic cs);
		logic hit;
		hit = (d == s);
		if (!cs && s >= CH_UPPER_A && s <= CH_UPPER_Z) begin
			hit = hit || (d == s + CASE_OFS);
		end
		if (!cs && s >= CH_LOWER_A && s <= CH_LOWER_Z) begin
			hit = hit || (d == s - CASE_OFS);
		end
		return hit;
	endfunction

endpackage

[sv/mdrs_if.sv]
// Channel interfaces: input bytes, result items and register writes.
interface mdrs_in_if import mdrs_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface mdrs_out_if import mdrs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [7:0]       out_byte;
	logic             is_data;
	logic             matched;
	logic [IDX_W-1:0] separator_index;
	logic             last;

	modport source (output valid, output out_byte, output is_data, output matched,
		output separator_index, output last, input ready);
	modport sink   (input valid, input out_byte, input is_data, input matched,
		input separator_index, input last, output ready);
endinterface

interface mdrs_cfg_if import mdrs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SEP_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/mdrs_cfg.sv]
// Configuration register file written through the register channel.
module mdrs_cfg import mdrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mdrs_cfg_if.sink    wr,
	output cfg_t        regs
);

	cfg_t cfg_q;

	assign wr.ready = 1'b1;
	assign regs     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep[0]          <= RST_SEP_0;
			cfg_q.sep[1]          <= RST_SEP_1;
			cfg_q.sep[2]          <= RST_SEP_2;
			cfg_q.sep[3]          <= RST_SEP_3;
			cfg_q.lengths         <= RST_LENGTHS;
			cfg_q.case_sensitive  <= RST_CASE;
			cfg_q.escape_enable   <= RST_ESC_EN;
			cfg_q.escape_byte     <= RST_ESC_BYTE;
		end else if (wr.valid && wr.ready) begin
			case (cfg_reg_t'(wr.index))
				REG_SEP_0:    cfg_q.sep[0]         <= wr.data;
				REG_SEP_1:    cfg_q.sep[1]         <= wr.data;
				REG_SEP_2:    cfg_q.sep[2]         <= wr.data;
				REG_SEP_3:    cfg_q.sep[3]         <= wr.data;
				REG_LENGTHS:  cfg_q.lengths        <= wr.data[LENS_W-1:0];
				REG_CASE:     cfg_q.case_sensitive <= wr.data[0];
				REG_ESC_EN:   cfg_q.escape_enable  <= wr.data[0];
				REG_ESC_BYTE: cfg_q.escape_byte    <= wr.data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[sv/mdrs_core.sv]
// Input register, separator window, match logic and drain load.
`include "multi_delimiter_record_splitter_top_defines.svh"

module mdrs_core import mdrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mdrs_in_if.sink     in_ch,
	input  cfg_t        regs,
	input  logic        drain_free,
	output drain_ld_t   dl
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        eoi_s1;

	logic [MAX_SEP_LEN-1:0][7:0] hist_q;
	logic [FILL_W-1:0]           fill_q;
	logic [FILL_W-1:0]           run_q;
	logic                        esc_q;

	logic [MAX_SEP_LEN-1:0][7:0] hist_n;
	logic [MAX_SEP_LEN-1:0][7:0] hist_d;
	logic [FILL_W-1:0]           fill_d;
	logic [FILL_W-1:0]           run_d;
	logic                        esc_d;

	logic                        step_fire;
	logic                        full;
	logic [FILL_W-1:0]           fill_push;
	logic [FILL_W-1:0]           run_push;
	logic [FILL_W-1:0]           fill_m1;
	logic [NUM_SEPARATORS-1:0][LEN_W-1:0] len;
	logic [NUM_SEPARATORS-1:0]   hit;
	logic [LEN_W-1:0]            best_len;
	logic [IDX_W-1:0]            best_k;
	logic [SUM_W-1:0]            n_match;
	logic                        is_escape;

	assign step_fire   = valid_s1 && drain_free;
	assign in_ch.ready = !valid_s1 || step_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (step_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			eoi_s1  <= in_ch.end_of_input;
		end
	end

	assign full      = (fill_q == FILL_W'(MAX_SEP_LEN));
	assign fill_push = full ? fill_q : fill_q + FILL_W'(1);
	assign run_push  = (run_q == FILL_W'(MAX_SEP_LEN)) ? run_q : run_q + FILL_W'(1);
	assign fill_m1   = fill_q - FILL_W'(1);
	assign is_escape = regs.escape_enable && (byte_s1 == regs.escape_byte);

	always_comb begin
		hist_n[0] = byte_s1;
		for (int j = 1; j < MAX_SEP_LEN; j++) begin
			hist_n[j] = hist_q[j-1];
		end
	end

	// newest byte sits at position zero, so separator byte m lines up with len-1-m
	always_comb begin
		for (int k = 0; k < NUM_SEPARATORS; k++) begin
			len[k] = regs.lengths[LEN_W*k +: LEN_W];
			hit[k] = (len[k] != '0) && (len[k] <= LEN_W'(MAX_SEP_LEN)) &&
				(len[k] <= LEN_W'(run_push)) && (len[k] <= LEN_W'(fill_push));
			for (int j = 0; j < MAX_SEP_LEN; j++) begin
				if (LEN_W'(j) < len[k] && !bytes_equal(hist_n[j],
						8'(regs.sep[k] >> (8 * (int'(len[k]) - j - 1))),
						regs.case_sensitive)) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

	// longest wins, lower index on a tie
	always_comb begin
		best_len = '0;
		best_k   = '0;
		for (int k = 0; k < NUM_SEPARATORS; k++) begin
			if (hit[k] && len[k] > best_len) begin
				best_len = len[k];
				best_k   = IDX_W'(k);
			end
		end
	end

	assign n_match = SUM_W'(fill_q) + SUM_W'(1) - SUM_W'(best_len);

	always_comb begin
		hist_d     = hist_q;
		fill_d     = fill_q;
		run_d      = run_q;
		esc_d      = esc_q;
		dl.load    = step_fire;
		dl.hist    = hist_q;
		dl.pos     = fill_m1[POS_W-1:0];
		dl.cnt     = '0;
		dl.term    = 1'b0;
		dl.matched = 1'b0;
		dl.idx     = '0;
		if (eoi_s1) begin
			dl.cnt  = fill_q;
			dl.term = 1'b1;
			fill_d  = '0;
			run_d   = '0;
			esc_d   = 1'b0;
		end else if (esc_q) begin
			hist_d = hist_n;
			fill_d = fill_push;
			run_d  = '0;
			esc_d  = 1'b0;
			dl.cnt = full ? FILL_W'(1) : '0;
		end else if (is_escape) begin
			esc_d = 1'b1;
		end else if (best_len != '0) begin
			dl.cnt     = n_match[FILL_W-1:0];
			dl.term    = 1'b1;
			dl.matched = 1'b1;
			dl.idx     = best_k;
			fill_d     = '0;
			run_d      = '0;
		end else begin
			hist_d = hist_n;
			fill_d = fill_push;
			run_d  = run_push;
			dl.cnt = full ? FILL_W'(1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			run_q  <= '0;
			esc_q  <= 1'b0;
		end else if (step_fire) begin
			fill_q <= fill_d;
			run_q  <= run_d;
			esc_q  <= esc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			hist_q <= hist_d;
		end
	end

	`MDRS_ASSERT(a_fill_range, fill_q <= FILL_W'(MAX_SEP_LEN), "window fill out of range")
	`MDRS_ASSERT(a_run_le_fill, run_q <= fill_q, "escape run exceeds window fill")
	`MDRS_ASSERT_NEXT(a_term_clears, dl.load && dl.term, fill_q == '0 && run_q == '0 && !esc_q, "window not cleared after terminator")

endmodule

[sv/mdrs_emit.sv]
// Drain buffer and output register: one result transaction per cycle unless res stalls.
`include "multi_delimiter_record_splitter_top_defines.svh"

module mdrs_emit import mdrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  drain_ld_t   dl,
	output logic        drain_free,
	mdrs_out_if.source  res
);

	logic [MAX_SEP_LEN-1:0][7:0] d_hist_q;
	logic [POS_W-1:0]            d_pos_q;
	logic [FILL_W-1:0]           d_cnt_q;
	logic                        d_term_q;
	logic                        d_matched_q;
	logic [IDX_W-1:0]            d_idx_q;

	logic                        o_valid_q;
	logic [7:0]                  o_byte_q;
	logic                        o_is_data_q;
	logic                        o_matched_q;
	logic [IDX_W-1:0]            o_idx_q;
	logic                        o_last_q;

	logic                        pend;
	logic                        o_free;
	logic                        mv;
	logic                        mv_data;
	logic                        mv_last;

	assign pend       = (d_cnt_q != '0) || d_term_q;
	assign o_free     = !o_valid_q || res.ready;
	assign mv         = pend && o_free;
	assign mv_data    = (d_cnt_q != '0);
	assign mv_last    = mv_data ? (d_cnt_q == FILL_W'(1) && !d_term_q) : 1'b1;
	assign drain_free = !pend || (mv && mv_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_cnt_q   <= '0;
			d_term_q  <= 1'b0;
			d_pos_q   <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (dl.load) begin
				d_cnt_q  <= dl.cnt;
				d_term_q <= dl.term;
				d_pos_q  <= dl.pos;
			end else if (mv) begin
				if (mv_data) begin
					d_cnt_q <= d_cnt_q - FILL_W'(1);
					d_pos_q <= d_pos_q - POS_W'(1);
				end else begin
					d_term_q <= 1'b0;
				end
			end
			if (mv) begin
				o_valid_q <= 1'b1;
			end else if (res.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dl.load) begin
			d_hist_q    <= dl.hist;
			d_matched_q <= dl.matched;
			d_idx_q     <= dl.idx;
		end
		if (mv) begin
			o_byte_q    <= mv_data ? d_hist_q[d_pos_q] : 8'd0;
			o_is_data_q <= mv_data;
			o_matched_q <= mv_data ? 1'b0 : d_matched_q;
			o_idx_q     <= mv_data ? '0 : d_idx_q;
			o_last_q    <= mv_last;
		end
	end

	assign res.valid           = o_valid_q;
	assign res.out_byte        = o_byte_q;
	assign res.is_data         = o_is_data_q;
	assign res.matched         = o_matched_q;
	assign res.separator_index = o_idx_q;
	assign res.last            = o_last_q;

	`MDRS_ASSERT(a_term_last, o_valid_q && !o_is_data_q |-> o_last_q, "terminator without last")
	`MDRS_ASSERT(a_load_free, dl.load |-> drain_free, "drain loaded while busy")
	`MDRS_ASSERT_NEXT(a_drain_done, mv && mv_last && !dl.load, d_cnt_q == '0 && !d_term_q, "drain not empty after last result")

endmodule

[sv/multi_delimiter_record_splitter_top.sv]
// Top level of the multi-separator record splitter.
//
// data_in carries one stream byte or an end-of-input mark per transaction;
// data_out carries record bytes and record terminators, one per transaction,
// with last set on the final result of each input; cfg writes the eight
// configuration registers by index and is always ready.
// An accepted input reaches data_out through the input register, the match logic,
// the drain buffer and the output register. Throughput: one input per cycle while
// each input gives at most one result and data_out is not stalled.
// An input that ends a record gives up to nine results; they leave the drain
// buffer one per cycle while data_out is not stalled, and data_in stays low on
// ready until the last one has moved into the output register.
// Reset empties the window, clears any pending escape and loads the
// register defaults: line feed and CR-LF separators, exact compare, escape off.
// A stall on data_out holds the output register and the drain buffer; one
// further input waits in the input register, then data_in ready drops.
module multi_delimiter_record_splitter_top import mdrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mdrs_in_if.sink     data_in,
	mdrs_out_if.source  data_out,
	mdrs_cfg_if.sink    cfg
);

	cfg_t      regs;
	drain_ld_t dl;
	logic      drain_free;

	mdrs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.regs   (regs)
	);

	mdrs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (data_in),
		.regs       (regs),
		.drain_free (drain_free),
		.dl         (dl)
	);

	mdrs_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.dl         (dl),
		.drain_free (drain_free),
		.res        (data_out)
	);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the multi-separator record splitter: directed and random streams.
module tb;
	import mdrs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 40;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} stream_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             is_data;
		logic             matched;
		logic [IDX_W-1:0] separator_index;
		logic             last;
	} record_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mdrs_in_if  in_ch ();
	mdrs_out_if out_ch ();
	mdrs_cfg_if cfg_ch ();

	multi_delimiter_record_splitter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_in  (in_ch),
		.data_out (out_ch),
		.cfg      (cfg_ch)
	);

	logic [7:0]        pend_bytes [MAX_SEP_LEN];
	int                pend_fill;
	int                run_len;
	bit                esc_armed;
	logic [SEP_W-1:0]  sep_val [NUM_SEPARATORS];
	logic [LENS_W-1:0] sep_lens;
	bit                exact_case;
	bit                esc_on;
	logic [7:0]        esc_val;

	stream_item_t pending_items [$];
	record_item_t expected_out [$];
	stream_item_t next_item;
	stream_item_t taken_item;
	record_item_t want;

	int items_queued = 0;
	int inputs_offered = 0;
	int inputs_accepted = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit steady = 1'b0;
	int cycle_count = 0;
	int mismatches = 0;
	int produced = 0;
	int data_seen = 0;
	int ends_seen = 0;
	int hits_seen [NUM_SEPARATORS];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("ERROR at cycle %0d: %s", cycle_count, msg);
		end
	endtask

	function automatic bit byte_hit(logic [7:0] d, logic [7:0] s);
		int di;
		int si;
		di = d;
		si = s;
		if (di == si) return 1'b1;
		if (exact_case) return 1'b0;
		if (s >= CH_UPPER_A && s <= CH_UPPER_Z) return di == si + int'(CASE_OFS);
		if (s >= CH_LOWER_A && s <= CH_LOWER_Z) return di + int'(CASE_OFS) == si;
		return 1'b0;
	endfunction

	function automatic bit sep_hit(int k, int len);
		int base;
		int m;
		base = pend_fill - len;
		for (m = 0; m < len; m++) begin
			if (!byte_hit(pend_bytes[(base + m) % MAX_SEP_LEN], sep_val[k][8*m +: 8])) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic add_result(logic [7:0] b, logic is_data, logic matched,
		logic [IDX_W-1:0] idx);
		record_item_t r;
		r.out_byte = b;
		r.is_data = is_data;
		r.matched = matched;
		r.separator_index = idx;
		r.last = 1'b0;
		expected_out.push_back(r);
		produced++;
	endtask

	task automatic shift_in(logic [7:0] b);
		int i;
		if (pend_fill >= MAX_SEP_LEN) begin
			add_result(pend_bytes[0], 1'b1, 1'b0, '0);
			for (i = 0; i < MAX_SEP_LEN - 1; i++) pend_bytes[i] = pend_bytes[i + 1];
			pend_fill = MAX_SEP_LEN - 1;
		end
		pend_bytes[pend_fill] = b;
		pend_fill++;
	endtask

	task automatic drain_window(int keep);
		int i;
		for (i = 0; i + keep < pend_fill; i++) add_result(pend_bytes[i], 1'b1, 1'b0, '0);
		pend_fill = 0;
		run_len = 0;
	endtask

	task automatic split_input(stream_item_t it);
		int best_len;
		int best_k;
		int len;
		int k;
		record_item_t r;
		produced = 0;
		best_len = 0;
		best_k = 0;
		if (it.end_of_input) begin
			drain_window(0);
			esc_armed = 1'b0;
			add_result(8'h00, 1'b0, 1'b0, '0);
		end else if (esc_armed) begin
			shift_in(it.data_byte);
			esc_armed = 1'b0;
			run_len = 0;
		end else if (esc_on && it.data_byte == esc_val) begin
			esc_armed = 1'b1;
		end else begin
			shift_in(it.data_byte);
			if (run_len < MAX_SEP_LEN) run_len++;
			for (k = 0; k < NUM_SEPARATORS; k++) begin
				len = sep_lens[4*k +: 4];
				if (len == 0 || len > MAX_SEP_LEN) continue;
				if (len > run_len || len > pend_fill || len <= best_len) continue;
				if (sep_hit(k, len)) begin
					best_len = len;
					best_k = k;
				end
			end
			if (best_len > 0) begin
				drain_window(best_len);
				add_result(8'h00, 1'b0, 1'b1, best_k[IDX_W-1:0]);
			end
		end
		if (produced > 0) begin
			r = expected_out.pop_back();
			r.last = 1'b1;
			expected_out.push_back(r);
		end
	endtask

	task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SEP_W-1:0] v);
		case (cfg_reg_t'(idx))
			REG_SEP_0:    sep_val[0] = v;
			REG_SEP_1:    sep_val[1] = v;
			REG_SEP_2:    sep_val[2] = v;
			REG_SEP_3:    sep_val[3] = v;
			REG_LENGTHS:  sep_lens = v[LENS_W-1:0];
			REG_CASE:     exact_case = v[0];
			REG_ESC_EN:   esc_on = v[0];
			REG_ESC_BYTE: esc_val = v[7:0];
			default:      ;
		endcase
	endtask

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] flip_case(logic [7:0] b);
		if (exact_case || $urandom_range(0, 1) == 0) return b;
		if (b >= CH_UPPER_A && b <= CH_UPPER_Z) return b + CASE_OFS;
		if (b >= CH_LOWER_A && b <= CH_LOWER_Z) return b - CASE_OFS;
		return b;
	endfunction

	function automatic logic [7:0] sep_byte_pick();
		case ($urandom_range(0, 11))
			0:       return "a";
			1:       return "b";
			2:       return "B";
			3:       return "Z";
			4:       return "z";
			5:       return "@";
			6:       return "[";
			7:       return 8'h60;
			8:       return "{";
			9:       return 8'h00;
			10:      return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [SEP_W-1:0] random_sep_value();
		logic [SEP_W-1:0] v;
		int m;
		for (m = 0; m < MAX_SEP_LEN; m++) v[8*m +: 8] = sep_byte_pick();
		return v;
	endfunction

	function automatic logic [3:0] random_len();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 4'd0;
		if (r == 1) return 4'($urandom_range(MAX_SEP_LEN + 1, 15));
		return 4'($urandom_range(1, MAX_SEP_LEN));
	endfunction

	task automatic queue_byte(logic [7:0] b);
		stream_item_t it;
		it.data_byte = b;
		it.end_of_input = 1'b0;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_end();
		stream_item_t it;
		it.data_byte = 8'($urandom_range(0, 255));
		it.end_of_input = 1'b1;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) queue_byte(s[i]);
	endtask

	task automatic queue_sep_bytes(int k, int n);
		int m;
		for (m = 0; m < n; m++) queue_byte(flip_case(sep_val[k][8*m +: 8]));
	endtask

	task automatic add_random_items(int n);
		int added;
		int r;
		int k;
		int len;
		int part;
		added = 0;
		while (added < n) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, NUM_SEPARATORS - 1);
			len = sep_lens[4*k +: 4];
			if (r < 45 && len >= 1 && len <= MAX_SEP_LEN) begin
				queue_sep_bytes(k, len);
				added += len;
			end else if (r < 55 && len >= 2 && len <= MAX_SEP_LEN) begin
				part = $urandom_range(1, len - 1);
				queue_sep_bytes(k, part);
				added += part;
			end else if (r < 63 && esc_on) begin
				queue_byte(esc_val);
				added++;
			end else if (r < 70) begin
				queue_end();
				added++;
			end else if (r < 85) begin
				queue_byte(flip_case(sep_val[k][8*$urandom_range(0, MAX_SEP_LEN - 1) +: 8]));
				added++;
			end else begin
				queue_byte(8'($urandom_range(0, 255)));
				added++;
			end
		end
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [SEP_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (!(pending_items.size() == 0 && inputs_accepted == items_queued &&
			expected_out.size() == 0)) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_config();
		write_reg(REG_SEP_0, random_sep_value());
		write_reg(REG_SEP_1, random_sep_value());
		write_reg(REG_SEP_2, random_sep_value());
		write_reg(REG_SEP_3, random_sep_value());
		write_reg(REG_LENGTHS, 64'({random_len(), random_len(), random_len(), random_len()}));
		write_reg(REG_CASE, 64'($urandom_range(0, 1)));
		write_reg(REG_ESC_EN, 64'($urandom_range(0, 1)));
		write_reg(REG_ESC_BYTE, 64'(sep_byte_pick()));
	endtask

	// source side: hold until the transaction is taken, then gap or advance
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= 8'h00;
			in_ch.end_of_input <= 1'b0;
		end else if (!(in_ch.valid && inputs_accepted != inputs_offered)) begin
			if (gap_left > 0) begin
				in_ch.valid <= 1'b0;
				gap_left--;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= next_item.data_byte;
				in_ch.end_of_input <= next_item.end_of_input;
				inputs_offered++;
				gap_left = idle_span();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_left = idle_span();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
			if (in_ch.valid && in_ch.ready) begin
				taken_item.data_byte = in_ch.data_byte;
				taken_item.end_of_input = in_ch.end_of_input;
				split_input(taken_item);
				inputs_accepted++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %02h is_data %b matched %b",
						out_ch.out_byte, out_ch.is_data, out_ch.matched));
				end else begin
					want = expected_out.pop_front();
					if (out_ch.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_ch.out_byte, want.out_byte));
					if (out_ch.is_data !== want.is_data)
						report_mismatch($sformatf("is_data %b, expected %b",
							out_ch.is_data, want.is_data));
					if (out_ch.matched !== want.matched)
						report_mismatch($sformatf("matched %b, expected %b",
							out_ch.matched, want.matched));
					if (out_ch.separator_index !== want.separator_index)
						report_mismatch($sformatf("separator_index %0d, expected %0d",
							out_ch.separator_index, want.separator_index));
					if (out_ch.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b", out_ch.last, want.last));
					if (want.is_data) data_seen++;
					else if (want.matched) hits_seen[want.separator_index]++;
					else ends_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if ($urandom_range(0, 63) == 0) steady = !steady;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SEP_0;
		cfg_ch.data = '0;
		sep_val[0] = RST_SEP_0;
		sep_val[1] = RST_SEP_1;
		sep_val[2] = RST_SEP_2;
		sep_val[3] = RST_SEP_3;
		sep_lens = RST_LENGTHS;
		exact_case = RST_CASE;
		esc_on = RST_ESC_EN;
		esc_val = RST_ESC_BYTE;
		pend_fill = 0;
		run_len = 0;
		esc_armed = 1'b0;
		foreach (hits_seen[i]) hits_seen[i] = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_text("\r\n");
		queue_byte(RST_ESC_BYTE);
		queue_end();
		queue_end();
		add_random_items(15);
		wait_drained();
		add_random_items(15);
		wait_drained();

		write_reg(REG_SEP_0, '1);
		write_reg(REG_SEP_1, 64'h6261);
		write_reg(REG_SEP_2, 64'h4241);
		write_reg(REG_SEP_3, 64'h3B);
		write_reg(REG_LENGTHS, 64'h1228);
		write_reg(REG_CASE, 64'd0);
		write_reg(REG_ESC_EN, 64'd1);
		write_reg(REG_ESC_BYTE, 64'h00);
		queue_text("Ab");
		queue_byte(8'h00);
		queue_text(";");
		queue_byte(8'h00);
		queue_text("ab;");
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_end();
		add_random_items(20);
		wait_drained();

		write_reg(REG_SEP_0, random_sep_value());
		write_reg(REG_SEP_1, 64'hFFFF_FFFF_FF59_2C78);
		write_reg(REG_SEP_2, '0);
		write_reg(REG_SEP_3, '1);
		write_reg(REG_LENGTHS, 64'hF930);
		write_reg(REG_CASE, 64'd1);
		write_reg(REG_ESC_EN, 64'd0);
		write_reg(REG_ESC_BYTE, 64'hFF);
		queue_sep_bytes(1, 3);
		queue_byte(8'hFF);
		add_random_items(20);
		wait_drained();

		write_reg(REG_LENGTHS, 64'hFFFF);
		add_random_items(6);
		queue_end();
		wait_drained();

		write_reg(REG_LENGTHS, 64'h0000);
		add_random_items(6);
		queue_end();
		wait_drained();

		repeat (3) begin
			random_config();
			add_random_items(10);
			wait_drained();
		end

		$display("Stream of %0d inputs over eight register settings gave %0d record bytes.",
			items_queued, data_seen);
		$display("Records closed by separator 0..3: %0d %0d %0d %0d, by end of input: %0d",
			hits_seen[0], hits_seen[1], hits_seen[2], hits_seen[3], ends_seen);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
